/* design/rvc_instruction_expander_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the compressed instruction expander
// Concurrent assertion wrappers, sampled on clk; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef RVC_INSTRUCTION_EXPANDER_TOP_ASSERT_SVH
`define RVC_INSTRUCTION_EXPANDER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define RVCX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define RVCX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVCX_ASSERT(lbl, prop, msg)
`define RVCX_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/rvcx_pkg.sv */
// ----------------------------------------------------------------------------
// rvcx_pkg
// Opcodes, compressed instruction codes and encoding helpers for the expander.
// ----------------------------------------------------------------------------
package rvcx_pkg;

  // Base ISA major opcodes.
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_STORE_FP = 7'h27;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6F;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

  // Base ISA funct3 values.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_DBL  = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_SUB  = 7'h20;
  // Upper immediate bits that turn SRLI into SRAI.
  localparam logic [5:0] SRAI_MARK = 6'b010000;

  // Architectural registers with a fixed role.
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  // Compressed instruction keys: {funct3, quadrant}.
  localparam logic [4:0] C_ADDI4SPN = 5'b000_00;
  localparam logic [4:0] C_FLD      = 5'b001_00;
  localparam logic [4:0] C_LW       = 5'b010_00;
  localparam logic [4:0] C_FLW      = 5'b011_00;
  localparam logic [4:0] C_RSV_Q0   = 5'b100_00;
  localparam logic [4:0] C_FSD      = 5'b101_00;
  localparam logic [4:0] C_SW       = 5'b110_00;
  localparam logic [4:0] C_FSW      = 5'b111_00;
  localparam logic [4:0] C_ADDI     = 5'b000_01;
  localparam logic [4:0] C_JAL      = 5'b001_01;
  localparam logic [4:0] C_LI       = 5'b010_01;
  localparam logic [4:0] C_LUI      = 5'b011_01;
  localparam logic [4:0] C_MISC_ALU = 5'b100_01;
  localparam logic [4:0] C_J        = 5'b101_01;
  localparam logic [4:0] C_BEQZ     = 5'b110_01;
  localparam logic [4:0] C_BNEZ     = 5'b111_01;
  localparam logic [4:0] C_SLLI     = 5'b000_10;
  localparam logic [4:0] C_FLDSP    = 5'b001_10;
  localparam logic [4:0] C_LWSP     = 5'b010_10;
  localparam logic [4:0] C_FLWSP    = 5'b011_10;
  localparam logic [4:0] C_JR_MV    = 5'b100_10;
  localparam logic [4:0] C_FSDSP    = 5'b101_10;
  localparam logic [4:0] C_SWSP     = 5'b110_10;
  localparam logic [4:0] C_FSWSP    = 5'b111_10;

  // Sub-operations of the miscellaneous ALU group, bits 11:10.
  localparam logic [1:0] ALU_SRLI = 2'b00;
  localparam logic [1:0] ALU_SRAI = 2'b01;
  localparam logic [1:0] ALU_ANDI = 2'b10;
  localparam logic [1:0] ALU_REG  = 2'b11;

  // Register-register operations, bits 6:5.
  localparam logic [1:0] ARITH_SUB = 2'b00;
  localparam logic [1:0] ARITH_XOR = 2'b01;
  localparam logic [1:0] ARITH_OR  = 2'b10;
  localparam logic [1:0] ARITH_AND = 2'b11;

  function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                        input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [4:0] rd, input logic [2:0] f3,
                                        input logic [4:0] rs1, input logic [4:0] rs2,
                                        input logic [6:0] f7);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_s(input logic [6:0] op, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [2:0] f3,
                                        input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [12:0] imm);
    return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

endpackage

/* design/rvcx_expand.sv */
// ----------------------------------------------------------------------------
// rvcx_expand
// Combinational expansion of one 16-bit compressed instruction.
// ----------------------------------------------------------------------------
module rvcx_expand (
  input  logic [15:0] word,
  output logic [31:0] expanded,
  output logic        bad
);

  logic [4:0]  key;
  logic [4:0]  rd;
  logic [4:0]  rs2;
  logic [4:0]  rdp;
  logic [4:0]  rs1p;
  logic [11:0] imm6;
  logic [5:0]  sh6;
  logic [9:0]  u_4spn;
  logic [9:0]  u_16sp;
  logic [6:0]  uw;
  logic [7:0]  ud;
  logic [7:0]  lw;
  logic [8:0]  ld;
  logic [7:0]  sw;
  logic [8:0]  sd;
  logic [20:0] cj;
  logic [12:0] cb;
  logic [31:0] res;
  logic        ill;

  assign key  = {word[15:13], word[1:0]};
  assign rd   = word[11:7];
  assign rs2  = word[6:2];
  assign rdp  = {2'b01, word[4:2]};
  assign rs1p = {2'b01, word[9:7]};
  assign imm6 = {{7{word[12]}}, word[6:2]};
  assign sh6  = {word[12], word[6:2]};

  assign u_4spn = {word[10:7], word[12:11], word[5], word[6], 2'b00};
  assign u_16sp = {word[12], word[4:3], word[5], word[2], word[6], 4'b0000};
  assign uw     = {word[5], word[12:10], word[6], 2'b00};
  assign ud     = {word[6:5], word[12:10], 3'b000};
  assign lw     = {word[3:2], word[12], word[6:4], 2'b00};
  assign ld     = {word[4:2], word[12], word[6:5], 3'b000};
  assign sw     = {word[8:7], word[12:9], 2'b00};
  assign sd     = {word[9:7], word[12:10], 3'b000};
  assign cj     = {{9{word[12]}}, word[12], word[8], word[10:9], word[6], word[7],
                   word[2], word[11], word[5:3], 1'b0};
  assign cb     = {{4{word[12]}}, word[12], word[6:5], word[2], word[11:10],
                   word[4:3], 1'b0};

  always_comb begin
    res = '0;
    ill = 1'b0;
    unique case (key)
      rvcx_pkg::C_ADDI4SPN: begin
        if (u_4spn == '0) begin
          ill = 1'b1;
        end else begin
          res = rvcx_pkg::enc_i(rvcx_pkg::OPC_OP_IMM, rdp, rvcx_pkg::F3_ADD,
                                rvcx_pkg::REG_SP, {2'b00, u_4spn});
        end
      end
      rvcx_pkg::C_FLD: res = rvcx_pkg::enc_i(rvcx_pkg::OPC_LOAD_FP, rdp,
                                             rvcx_pkg::F3_DBL, rs1p, {4'b0, ud});
      rvcx_pkg::C_LW:  res = rvcx_pkg::enc_i(rvcx_pkg::OPC_LOAD, rdp,
                                             rvcx_pkg::F3_WORD, rs1p, {5'b0, uw});
      rvcx_pkg::C_FLW: res = rvcx_pkg::enc_i(rvcx_pkg::OPC_LOAD_FP, rdp,
                                             rvcx_pkg::F3_WORD, rs1p, {5'b0, uw});
      rvcx_pkg::C_RSV_Q0: ill = 1'b1;
      rvcx_pkg::C_FSD: res = rvcx_pkg::enc_s(rvcx_pkg::OPC_STORE_FP, rs1p, rdp,
                                             rvcx_pkg::F3_DBL, {4'b0, ud});
      rvcx_pkg::C_SW:  res = rvcx_pkg::enc_s(rvcx_pkg::OPC_STORE, rs1p, rdp,
                                             rvcx_pkg::F3_WORD, {5'b0, uw});
      rvcx_pkg::C_FSW: res = rvcx_pkg::enc_s(rvcx_pkg::OPC_STORE_FP, rs1p, rdp,
                                             rvcx_pkg::F3_WORD, {5'b0, uw});
      rvcx_pkg::C_ADDI: res = rvcx_pkg::enc_i(rvcx_pkg::OPC_OP_IMM, rd,
                                              rvcx_pkg::F3_ADD, rd, imm6);
      rvcx_pkg::C_JAL:  res = rvcx_pkg::enc_j(rvcx_pkg::REG_RA, cj);
      rvcx_pkg::C_LI:   res = rvcx_pkg::enc_i(rvcx_pkg::OPC_OP_IMM, rd,
                                              rvcx_pkg::F3_ADD, rvcx_pkg::REG_ZERO, imm6);
      rvcx_pkg::C_LUI: begin
        if (rd == rvcx_pkg::REG_SP) begin
          // ADDI16SP shares this slot.
          if (u_16sp == '0) begin
            ill = 1'b1;
          end else begin
            res = rvcx_pkg::enc_i(rvcx_pkg::OPC_OP_IMM, rvcx_pkg::REG_SP,
                                  rvcx_pkg::F3_ADD, rvcx_pkg::REG_SP,
                                  {{2{u_16sp[9]}}, u_16sp});
          end
        end else if (sh6 == '0) begin
          ill = 1'b1;
        end else begin
          res = {{15{word[12]}}, word[6:2], rd, rvcx_pkg::OPC_LUI};
        end
      end
      rvcx_pkg::C_MISC_ALU: begin
        unique case (word[11:10])
          rvcx_pkg::ALU_SRLI: begin
            if (sh6[5]) begin
              ill = 1'b1;
            end else begin
              res = rvcx_pkg::enc_i(rvcx_pkg::OPC_OP_IMM, rs1p, rvcx_pkg::F3_SR,
                                    rs1p, {6'b0, sh6});
            end
          end
          rvcx_pkg::ALU_SRAI: begin
            if (sh6[5]) begin
              ill = 1'b1;
            end else begin
              res = rvcx_pkg::enc_i(rvcx_pkg::OPC_OP_IMM, rs1p, rvcx_pkg::F3_SR,
                                    rs1p, {rvcx_pkg::SRAI_MARK, sh6});
            end
          end
          rvcx_pkg::ALU_ANDI: res = rvcx_pkg::enc_i(rvcx_pkg::OPC_OP_IMM, rs1p,
                                                    rvcx_pkg::F3_AND, rs1p, imm6);
          default: begin
            // Register forms; bit 12 set selects the RV64 word forms.
            if (word[12]) begin
              ill = 1'b1;
            end else begin
              unique case (word[6:5])
                rvcx_pkg::ARITH_SUB: res = rvcx_pkg::enc_r(rs1p, rvcx_pkg::F3_ADD, rs1p,
                                                           rdp, rvcx_pkg::F7_SUB);
                rvcx_pkg::ARITH_XOR: res = rvcx_pkg::enc_r(rs1p, rvcx_pkg::F3_XOR, rs1p,
                                                           rdp, rvcx_pkg::F7_BASE);
                rvcx_pkg::ARITH_OR:  res = rvcx_pkg::enc_r(rs1p, rvcx_pkg::F3_OR, rs1p,
                                                           rdp, rvcx_pkg::F7_BASE);
                default:             res = rvcx_pkg::enc_r(rs1p, rvcx_pkg::F3_AND, rs1p,
                                                           rdp, rvcx_pkg::F7_BASE);
              endcase
            end
          end
        endcase
      end
      rvcx_pkg::C_J:    res = rvcx_pkg::enc_j(rvcx_pkg::REG_ZERO, cj);
      rvcx_pkg::C_BEQZ: res = rvcx_pkg::enc_b(rvcx_pkg::F3_BEQ, rs1p, cb);
      rvcx_pkg::C_BNEZ: res = rvcx_pkg::enc_b(rvcx_pkg::F3_BNE, rs1p, cb);
      rvcx_pkg::C_SLLI: begin
        if (sh6[5]) begin
          ill = 1'b1;
        end else begin
          res = rvcx_pkg::enc_i(rvcx_pkg::OPC_OP_IMM, rd, rvcx_pkg::F3_SLL, rd,
                                {6'b0, sh6});
        end
      end
      rvcx_pkg::C_FLDSP: res = rvcx_pkg::enc_i(rvcx_pkg::OPC_LOAD_FP, rd, rvcx_pkg::F3_DBL,
                                               rvcx_pkg::REG_SP, {3'b0, ld});
      rvcx_pkg::C_LWSP: begin
        if (rd == rvcx_pkg::REG_ZERO) begin
          ill = 1'b1;
        end else begin
          res = rvcx_pkg::enc_i(rvcx_pkg::OPC_LOAD, rd, rvcx_pkg::F3_WORD,
                                rvcx_pkg::REG_SP, {4'b0, lw});
        end
      end
      rvcx_pkg::C_FLWSP: res = rvcx_pkg::enc_i(rvcx_pkg::OPC_LOAD_FP, rd, rvcx_pkg::F3_WORD,
                                               rvcx_pkg::REG_SP, {4'b0, lw});
      rvcx_pkg::C_JR_MV: begin
        if (!word[12]) begin
          if (rs2 != rvcx_pkg::REG_ZERO) begin
            res = rvcx_pkg::enc_r(rd, rvcx_pkg::F3_ADD, rvcx_pkg::REG_ZERO, rs2,
                                  rvcx_pkg::F7_BASE);
          end else if (rd == rvcx_pkg::REG_ZERO) begin
            ill = 1'b1;
          end else begin
            res = rvcx_pkg::enc_i(rvcx_pkg::OPC_JALR, rvcx_pkg::REG_ZERO,
                                  rvcx_pkg::F3_ADD, rd, 12'h000);
          end
        end else if (rs2 != rvcx_pkg::REG_ZERO) begin
          res = rvcx_pkg::enc_r(rd, rvcx_pkg::F3_ADD, rd, rs2, rvcx_pkg::F7_BASE);
        end else if (rd == rvcx_pkg::REG_ZERO) begin
          res = rvcx_pkg::EBREAK_WORD;
        end else begin
          res = rvcx_pkg::enc_i(rvcx_pkg::OPC_JALR, rvcx_pkg::REG_RA,
                                rvcx_pkg::F3_ADD, rd, 12'h000);
        end
      end
      rvcx_pkg::C_FSDSP: res = rvcx_pkg::enc_s(rvcx_pkg::OPC_STORE_FP, rvcx_pkg::REG_SP, rs2,
                                               rvcx_pkg::F3_DBL, {3'b0, sd});
      rvcx_pkg::C_SWSP:  res = rvcx_pkg::enc_s(rvcx_pkg::OPC_STORE, rvcx_pkg::REG_SP, rs2,
                                               rvcx_pkg::F3_WORD, {4'b0, sw});
      rvcx_pkg::C_FSWSP: res = rvcx_pkg::enc_s(rvcx_pkg::OPC_STORE_FP, rvcx_pkg::REG_SP, rs2,
                                               rvcx_pkg::F3_WORD, {4'b0, sw});
      // Quadrant 3 is not a compressed instruction.
      default: ill = 1'b1;
    endcase
  end

  assign expanded = ill ? 32'h0 : res;
  assign bad      = ill;

endmodule

/* design/rvc_instruction_expander_top.sv */
// ----------------------------------------------------------------------------
// rvc_instruction_expander_top
// RV32C compressed instruction expander with registered input and result.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake      | Payload
//  ---------+----------------+----------------------------------------
//  input    | start / busy   | compressed_word[15:0]
//  result   | done (strobe)  | expanded_word[31:0], illegal
//
// Every input transfer yields exactly one result transfer: the instruction is
// captured in an input register, expanded by a single layer of decode and
// field-muxing logic, and captured in the result register.
// busy is held low permanently, so a new instruction may be transferred in
// every cycle and the throughput is one instruction per clock.
// The receiver cannot stall the result; done is high for exactly one cycle
// per result. Synchronous reset (rst) clears both valid flags; payload
// registers are not reset.
// ----------------------------------------------------------------------------
`include "rvc_instruction_expander_top_assert.svh"

module rvc_instruction_expander_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] compressed_word,
  output logic        done,
  output logic [31:0] expanded_word,
  output logic        illegal
);

  // Input stage: the captured instruction and its valid flag.
  logic [15:0] word_q;
  logic        word_valid;

  // Combinational expansion of the registered instruction.
  logic [31:0] exp_word;
  logic        exp_bad;

  // The expander has no state and is purely combinational, so the block never
  // refuses a transfer.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else begin
      word_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      word_q <= compressed_word;
    end
  end

  rvcx_expand u_expand (
    .word     (word_q),
    .expanded (exp_word),
    .bad      (exp_bad)
  );

  // Result stage: the strobe is reset, the payload simply follows the input
  // stage whenever it holds a valid instruction.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid) begin
      expanded_word <= exp_word;
      illegal       <= exp_bad;
    end
  end

  // Every accepted instruction reaches the input stage on the next edge.
  `RVCX_ASSERT(a_accept_to_stage, start && !busy |=> word_valid, "accepted word was lost")
  // The input stage always produces a result strobe on the following edge.
  `RVCX_ASSERT(a_stage_to_done, word_valid |=> done, "expanded word was not delivered")
  // An illegal result carries an all-zero word.
  `RVCX_ASSERT(a_illegal_zero, done && illegal |-> expanded_word == 32'h0,
               "illegal result with a non-zero word")
  // A legal result is always a 32-bit encoding.
  `RVCX_ASSERT(a_legal_32bit, done && !illegal |-> expanded_word[1:0] == 2'b11,
               "legal result is not a 32-bit instruction")
  // Reset empties both stages.
  `RVCX_ASSERT_ALWAYS(a_reset_empty, rst |=> !done && !word_valid,
                      "pipeline not empty after reset")

endmodule

/* verif/rvcx_expansion_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvcx_expansion_check_pkg
// Expected-result calculation and result checking for the compressed
// instruction expander: every compressed word is expanded here on its own
// terms and compared with what the block delivers.
// ----------------------------------------------------------------------------
package rvcx_expansion_check_pkg;

  import rvcx_pkg::*;

  typedef struct packed {
    logic [15:0] source;
    logic [31:0] word;
    logic        illegal;
  } expansion_t;

  function automatic logic [31:0] itype_of(input logic [6:0] op, input logic [4:0] dst,
                                           input logic [2:0] f3, input logic [4:0] src,
                                           input logic [11:0] imm);
    return {imm, src, f3, dst, op};
  endfunction

  function automatic logic [31:0] stype_of(input logic [6:0] op, input logic [4:0] base,
                                           input logic [4:0] data, input logic [2:0] f3,
                                           input logic [11:0] imm);
    return {imm[11:5], data, base, f3, imm[4:0], op};
  endfunction

  function automatic logic [31:0] rtype_of(input logic [4:0] dst, input logic [2:0] f3,
                                           input logic [4:0] src_a, input logic [4:0] src_b,
                                           input logic [6:0] f7);
    return {f7, src_b, src_a, f3, dst, OPC_OP};
  endfunction

  function automatic logic [31:0] btype_of(input logic [2:0] f3, input logic [4:0] src,
                                           input logic [12:0] imm);
    return {imm[12], imm[10:5], REG_ZERO, src, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] jtype_of(input logic [4:0] dst, input logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], dst, OPC_JAL};
  endfunction

  // Expands one compressed word into its 32-bit form and the illegal flag.
  function automatic expansion_t predict_expansion(input logic [15:0] w);
    expansion_t  r;
    logic        ok;
    logic [4:0]  rd, rs2, rdp, rs1p;
    logic [5:0]  sh;
    logic [11:0] imm6;
    logic [9:0]  a4spn, a16sp;
    logic [6:0]  uw;
    logic [7:0]  ud, lwsp, swsp;
    logic [8:0]  ldsp, sdsp;
    logic [20:0] jimm;
    logic [12:0] bimm;
    rd    = w[11:7];
    rs2   = w[6:2];
    rdp   = {2'b01, w[4:2]};
    rs1p  = {2'b01, w[9:7]};
    sh    = {w[12], w[6:2]};
    imm6  = {{6{w[12]}}, w[12], w[6:2]};
    a4spn = {w[10:7], w[12:11], w[5], w[6], 2'b00};
    a16sp = {w[12], w[4:3], w[5], w[2], w[6], 4'b0000};
    uw    = {w[5], w[12:10], w[6], 2'b00};
    ud    = {w[6:5], w[12:10], 3'b000};
    lwsp  = {w[3:2], w[12], w[6:4], 2'b00};
    ldsp  = {w[4:2], w[12], w[6:5], 3'b000};
    swsp  = {w[8:7], w[12:9], 2'b00};
    sdsp  = {w[9:7], w[12:10], 3'b000};
    jimm  = {{9{w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
    bimm  = {{4{w[12]}}, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
    ok = 1'b1;
    r.source = w;
    r.word = '0;
    case ({w[15:13], w[1:0]})
      C_ADDI4SPN: begin
        if (a4spn == '0) ok = 1'b0;
        else r.word = itype_of(OPC_OP_IMM, rdp, F3_ADD, REG_SP, {2'b00, a4spn});
      end
      C_FLD:  r.word = itype_of(OPC_LOAD_FP, rdp, F3_DBL, rs1p, {4'b0, ud});
      C_LW:   r.word = itype_of(OPC_LOAD, rdp, F3_WORD, rs1p, {5'b0, uw});
      C_FLW:  r.word = itype_of(OPC_LOAD_FP, rdp, F3_WORD, rs1p, {5'b0, uw});
      C_FSD:  r.word = stype_of(OPC_STORE_FP, rs1p, rdp, F3_DBL, {4'b0, ud});
      C_SW:   r.word = stype_of(OPC_STORE, rs1p, rdp, F3_WORD, {5'b0, uw});
      C_FSW:  r.word = stype_of(OPC_STORE_FP, rs1p, rdp, F3_WORD, {5'b0, uw});
      C_ADDI: r.word = itype_of(OPC_OP_IMM, rd, F3_ADD, rd, imm6);
      C_JAL:  r.word = jtype_of(REG_RA, jimm);
      C_LI:   r.word = itype_of(OPC_OP_IMM, rd, F3_ADD, REG_ZERO, imm6);
      C_LUI: begin
        if (rd == REG_SP) begin
          if (a16sp == '0) ok = 1'b0;
          else r.word = itype_of(OPC_OP_IMM, REG_SP, F3_ADD, REG_SP, {{2{a16sp[9]}}, a16sp});
        end else if (sh == '0) begin
          ok = 1'b0;
        end else begin
          r.word = {{14{sh[5]}}, sh, rd, OPC_LUI};
        end
      end
      C_MISC_ALU: begin
        case (w[11:10])
          ALU_SRLI: begin
            if (sh[5]) ok = 1'b0;
            else r.word = itype_of(OPC_OP_IMM, rs1p, F3_SR, rs1p, {6'b0, sh});
          end
          ALU_SRAI: begin
            if (sh[5]) ok = 1'b0;
            else r.word = itype_of(OPC_OP_IMM, rs1p, F3_SR, rs1p, {SRAI_MARK, sh});
          end
          ALU_ANDI: r.word = itype_of(OPC_OP_IMM, rs1p, F3_AND, rs1p, imm6);
          default: begin
            if (w[12]) begin
              ok = 1'b0;
            end else begin
              case (w[6:5])
                ARITH_SUB: r.word = rtype_of(rs1p, F3_ADD, rs1p, rdp, F7_SUB);
                ARITH_XOR: r.word = rtype_of(rs1p, F3_XOR, rs1p, rdp, F7_BASE);
                ARITH_OR:  r.word = rtype_of(rs1p, F3_OR, rs1p, rdp, F7_BASE);
                default:   r.word = rtype_of(rs1p, F3_AND, rs1p, rdp, F7_BASE);
              endcase
            end
          end
        endcase
      end
      C_J:    r.word = jtype_of(REG_ZERO, jimm);
      C_BEQZ: r.word = btype_of(F3_BEQ, rs1p, bimm);
      C_BNEZ: r.word = btype_of(F3_BNE, rs1p, bimm);
      C_SLLI: begin
        if (sh[5]) ok = 1'b0;
        else r.word = itype_of(OPC_OP_IMM, rd, F3_SLL, rd, {6'b0, sh});
      end
      C_FLDSP: r.word = itype_of(OPC_LOAD_FP, rd, F3_DBL, REG_SP, {3'b0, ldsp});
      C_LWSP: begin
        if (rd == REG_ZERO) ok = 1'b0;
        else r.word = itype_of(OPC_LOAD, rd, F3_WORD, REG_SP, {4'b0, lwsp});
      end
      C_FLWSP: r.word = itype_of(OPC_LOAD_FP, rd, F3_WORD, REG_SP, {4'b0, lwsp});
      C_JR_MV: begin
        if (!w[12]) begin
          if (rs2 != REG_ZERO) r.word = rtype_of(rd, F3_ADD, REG_ZERO, rs2, F7_BASE);
          else if (rd == REG_ZERO) ok = 1'b0;
          else r.word = itype_of(OPC_JALR, REG_ZERO, F3_ADD, rd, 12'd0);
        end else begin
          if (rs2 != REG_ZERO) r.word = rtype_of(rd, F3_ADD, rd, rs2, F7_BASE);
          else if (rd == REG_ZERO) r.word = EBREAK_WORD;
          else r.word = itype_of(OPC_JALR, REG_RA, F3_ADD, rd, 12'd0);
        end
      end
      C_FSDSP: r.word = stype_of(OPC_STORE_FP, REG_SP, rs2, F3_DBL, {3'b0, sdsp});
      C_SWSP:  r.word = stype_of(OPC_STORE, REG_SP, rs2, F3_WORD, {4'b0, swsp});
      C_FSWSP: r.word = stype_of(OPC_STORE_FP, REG_SP, rs2, F3_WORD, {4'b0, swsp});
      // The reserved quadrant 0 slot and every quadrant 3 word.
      default: ok = 1'b0;
    endcase
    if (!ok) r.word = '0;
    r.illegal = !ok;
    return r;
  endfunction

  class rvc_expansion_scoreboard;

    expansion_t  awaited_q[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function void record_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // An instruction went in: queue the expansion it must produce.
    function void note_instruction(input logic [15:0] cw);
      awaited_q.push_back(predict_expansion(cw));
    endfunction

    function void check_result(input logic [31:0] word, input logic ill);
      expansion_t want;
      if (awaited_q.size() == 0) begin
        record_failure($sformatf("unexpected result: expanded_word %h illegal %b", word, ill));
        return;
      end
      want = awaited_q.pop_front();
      if (word !== want.word)
        record_failure($sformatf("c.%h expanded_word: expected %h, got %h",
                                 want.source, want.word, word));
      if (ill !== want.illegal)
        record_failure($sformatf("c.%h illegal: expected %b, got %b",
                                 want.source, want.illegal, ill));
    endfunction

    function int unsigned outstanding();
      return awaited_q.size();
    endfunction

    function void close_out();
      foreach (awaited_q[i])
        record_failure($sformatf("c.%h: no result arrived", awaited_q[i].source));
      awaited_q.delete();
    endfunction

  endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the compressed instruction expander. A directed set walks
// every compressed form and the reserved encodings, then biased random words
// follow under three sender idling profiles. Every result is checked against
// an independent expansion of the word that went in.
// ----------------------------------------------------------------------------
module tb_top;

  import rvcx_pkg::*;
  import rvcx_expansion_check_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] compressed_word = 16'h0000;
  logic        busy;
  logic        done;
  logic [31:0] expanded_word;
  logic        illegal;

  rvc_expansion_scoreboard expansion_sb;

  // Percentage of cycles in which the sender holds back before a transfer.
  int unsigned sender_idle_pct = 37;

  // One word per compressed form, the field extremes (all-ones fields) and
  // each reserved or special encoding. Hints are covered by the random part.
  logic [15:0] directed_words [$] = '{
    16'h0000,   // all-zero word, which is also ADDI4SPN with a zero offset
    16'hFFFF,   // quadrant 3 with every bit set
    16'h1FFC,   // ADDI4SPN, largest offset
    16'h3FFC,   // FLD
    16'h5FFC,   // LW
    16'h7FFC,   // FLW
    16'h9FFC,   // quadrant 0 reserved slot
    16'hBFFC,   // FSD
    16'hDFFC,   // SW
    16'hFFFC,   // FSW
    16'h1FFD,   // ADDI, negative immediate
    16'h3FFD,   // JAL, negative offset
    16'h5FFD,   // LI
    16'h6081,   // LUI with a zero immediate, reserved
    16'h6101,   // ADDI16SP with a zero immediate, reserved
    16'h7105,   // ADDI16SP
    16'h9001,   // SRLI with shift amount bit 5, reserved on RV32
    16'h847D,   // SRAI
    16'h9BFD,   // ANDI
    16'h8C01,   // SUB
    16'h8C21,   // XOR
    16'h8C41,   // OR
    16'h8C61,   // AND
    16'h9C01,   // SUBW slot, reserved on RV32
    16'hBFFD,   // J
    16'hDFFD,   // BEQZ
    16'hFFFD,   // BNEZ
    16'h1FFE,   // SLLI with shift amount bit 5, reserved on RV32
    16'h3FFE,   // FLDSP
    16'h4002,   // LWSP with rd zero, reserved
    16'h7FFE,   // FLWSP
    16'h8002,   // JR with rs1 zero, reserved
    16'h8F82,   // JR
    16'h8FFE,   // MV
    16'h9002,   // EBREAK
    16'h9F82,   // JALR
    16'h9FFE,   // ADD
    16'hBFFE,   // FSDSP
    16'hDFFE,   // SWSP
    16'hFFFE    // FSWSP
  };

  rvc_instruction_expander_top uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .compressed_word (compressed_word),
    .done            (done),
    .expanded_word   (expanded_word),
    .illegal         (illegal)
  );

  always #1 clk = ~clk;

  // Both channels are observed at the rising edge. A result can never share
  // an edge with the transfer that caused it, so the order of the two calls
  // below does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) expansion_sb.check_result(expanded_word, illegal);
      if (start && !busy) expansion_sb.note_instruction(compressed_word);
    end
  end

  // Mostly legal quadrants, with register and immediate fields often forced to
  // zero (or rd to the stack pointer) so that the reserved and special forms
  // turn up regularly rather than by luck.
  function automatic logic [15:0] random_instruction();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(99) < 85) w[1:0] = 2'($urandom_range(2));
    if ($urandom_range(99) < 20) w[11:7] = REG_ZERO;
    else if ($urandom_range(99) < 6) w[11:7] = REG_SP;
    if ($urandom_range(99) < 20) w[6:2] = REG_ZERO;
    if ($urandom_range(99) < 15) w[12] = 1'b0;
    return w;
  endfunction

  // Called just after a falling edge and returns just after one. While the
  // sender idles the word bus carries junk, which the block must ignore.
  task automatic send_instruction(input logic [15:0] cw);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      compressed_word <= 16'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    compressed_word <= cw;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Holds the sender off until every transfer has produced its result, then
  // idles on as the caller asks. The guard keeps a lost result from hanging
  // the run; the missing expectation is reported at the end.
  task automatic pause_until_drained(input int unsigned extra_cycles);
    int unsigned spins;
    spins = 0;
    start <= 1'b0;
    while (expansion_sb.outstanding() != 0 && spins < 1000) begin
      @(negedge clk);
      spins++;
    end
    repeat (extra_cycles) @(negedge clk);
  endtask

  initial begin
    expansion_sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words and the first random batch with a moderately idle sender.
    foreach (directed_words[i]) send_instruction(directed_words[i]);
    repeat (340) send_instruction(random_instruction());
    pause_until_drained(4);

    // A mostly idle sender, so gaps land on every stage of the pipeline.
    sender_idle_pct = 81;
    repeat (330) send_instruction(random_instruction());
    pause_until_drained(4);

    // Back-to-back transfers at full rate.
    sender_idle_pct = 0;
    repeat (330) send_instruction(random_instruction());
    pause_until_drained(8);

    expansion_sb.close_out();
    if (expansion_sb.failures == 0) begin
      $display("rvc_instruction_expander_top regression: pass");
    end else begin
      $display("rvc_instruction_expander_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("rvc_instruction_expander_top regression: fail");
    $finish;
  end

endmodule
